// ----- hw/rtl/histogram_equalization_defines.svh -----
// assertion macros shared by the histogram equalization rtl
`ifndef HISTOGRAM_EQUALIZATION_DEFINES_SVH
`define HISTOGRAM_EQUALIZATION_DEFINES_SVH
`ifndef SYNTH
`define HEQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("heq assertion failed");
`define HEQ_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("heq reset assertion failed");
`else
`define HEQ_ASSERT(lbl, prop)
`define HEQ_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- hw/rtl/heq_pkg.sv -----
// constants, codes and types of the histogram equalization block
`timescale 1ns / 1ps
package heq_pkg;

  localparam int GRAY_LEVELS = 256;
  localparam int MAX_DIM     = 1024;

  localparam int LVL_W  = $clog2(GRAY_LEVELS);
  localparam int FUNC_W = 2;
  localparam int PIX_W  = 8;
  localparam int OUT_W  = 8;
  localparam int DIM_W  = 11;
  localparam int BIN_W  = 21;
  localparam int CUM_W  = BIN_W + LVL_W;
  localparam int NUM_W  = CUM_W + OUT_W;
  localparam int TOT_W  = 2 * $clog2(MAX_DIM) + 1;
  localparam int REM_W  = TOT_W + OUT_W;
  localparam int CNT_W  = $clog2(OUT_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
  localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(400);

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MAP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [TOT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OUT_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- hw/rtl/heq_if.sv -----
// valid/ready channel interfaces of the histogram equalization block
`timescale 1ns / 1ps
interface heq_in_if ();
  logic                       valid;
  logic                       ready;
  logic [heq_pkg::FUNC_W-1:0] func;
  logic [heq_pkg::PIX_W-1:0]  pixel;
  modport source (output valid, func, pixel, input ready);
  modport sink (input valid, func, pixel, output ready);
endinterface

interface heq_out_if ();
  logic                      valid;
  logic                      ready;
  logic [heq_pkg::OUT_W-1:0] equalized_pixel;
  modport source (output valid, equalized_pixel, input ready);
  modport sink (input valid, equalized_pixel, output ready);
endinterface

interface heq_cfg_if ();
  logic                          valid;
  logic                          ready;
  logic [heq_pkg::CFG_IDX_W-1:0] index;
  logic [heq_pkg::DIM_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/histogram_equalization.sv -----
// histogram equalization top level: control sequencer, bin and table memories
// count item: bin read on accept, incremented bin written in S_CNTWR; clear item and
// unused code: done on accept; map item with a valid table: table read on accept,
// result loaded in S_MAPOUT, which waits while the output register is held; map item
// without a valid table: table build first, bin by bin through the bit-serial divider
// reset: histogram empty (bin valid flops cleared), table invalid, dims 400x400
`timescale 1ns / 1ps
`include "histogram_equalization_defines.svh"
module histogram_equalization (
  input  logic      clk_i,
  input  logic      rst_ni,
  heq_in_if.sink    pix_i,
  heq_out_if.source res_o,
  heq_cfg_if.sink   cfg_i
);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CNTWR  = 4'd1;
  localparam logic [3:0] S_MAPOUT = 4'd2;
  localparam logic [3:0] S_BINIT  = 4'd3;
  localparam logic [3:0] S_BRD    = 4'd4;
  localparam logic [3:0] S_BACC   = 4'd5;
  localparam logic [3:0] S_BMUL   = 4'd6;
  localparam logic [3:0] S_BDIV   = 4'd7;
  localparam logic [3:0] S_MAPRD  = 4'd8;

  localparam logic [heq_pkg::LVL_W-1:0] BIN_LAST = heq_pkg::LVL_W'(heq_pkg::GRAY_LEVELS - 1);
  localparam logic [heq_pkg::DIM_W-1:0] DIM_MAX  = heq_pkg::DIM_W'(heq_pkg::MAX_DIM);
  localparam logic [heq_pkg::DIM_W-1:0] DIM_ONE  = heq_pkg::DIM_W'(1);

  logic [3:0] state_q, state_d;

  // configuration registers
  logic [heq_pkg::DIM_W-1:0] width_q;
  logic [heq_pkg::DIM_W-1:0] height_q;

  // control state
  logic                          table_valid_q, table_valid_d;
  logic [heq_pkg::GRAY_LEVELS-1:0] bin_vld_q;
  logic [heq_pkg::LVL_W-1:0]     bin_q, bin_d;
  logic                          out_vld_q;

  // payload
  logic [heq_pkg::LVL_W-1:0] idx_q;
  logic [heq_pkg::TOT_W-1:0] total_q;
  logic [heq_pkg::CUM_W-1:0] cum_q;
  logic [heq_pkg::OUT_W-1:0] out_pix_q;
  logic                      bvld_rd_q;

  logic acc;
  logic out_load;

  // bin memory controls
  logic                      bin_we;
  logic                      bin_re;
  logic [heq_pkg::LVL_W-1:0] bin_raddr;
  logic [heq_pkg::BIN_W-1:0] bin_rdata;
  logic [heq_pkg::BIN_W-1:0] bin_eff;
  logic [heq_pkg::BIN_W-1:0] bin_inc;

  // transfer table controls
  logic                      tbl_we;
  logic                      tbl_re;
  logic [heq_pkg::LVL_W-1:0] tbl_raddr;
  logic [heq_pkg::OUT_W-1:0] tbl_rdata;

  // pixel total
  logic [heq_pkg::DIM_W-1:0]   w_cl;
  logic [heq_pkg::DIM_W-1:0]   h_cl;
  logic [2*heq_pkg::DIM_W-1:0] tot_prod;

  heq_pkg::div_req_t div_req;
  heq_pkg::div_rsp_t div_rsp;

  assign acc       = pix_i.valid && pix_i.ready;
  assign pix_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // a result waits in the output register while later items go on
  assign out_load    = (state_q == S_MAPOUT) && (!out_vld_q || res_o.ready);
  assign res_o.valid = out_vld_q;
  assign res_o.equalized_pixel = out_pix_q;

  // a bin never written since reset or clear reads as zero
  assign bin_eff = bvld_rd_q ? bin_rdata : '0;
  assign bin_inc = (bin_eff == heq_pkg::BIN_MAX) ? bin_eff : bin_eff + 1'b1;

  // dimensions clamped to 1..MAX_DIM before the total is formed
  always_comb begin
    w_cl = width_q;
    if (width_q == '0) begin
      w_cl = DIM_ONE;
    end else if (width_q > DIM_MAX) begin
      w_cl = DIM_MAX;
    end
    h_cl = height_q;
    if (height_q == '0) begin
      h_cl = DIM_ONE;
    end else if (height_q > DIM_MAX) begin
      h_cl = DIM_MAX;
    end
  end

  assign tot_prod = {{heq_pkg::DIM_W{1'b0}}, w_cl} * {{heq_pkg::DIM_W{1'b0}}, h_cl};

  // cum * 255 as a shift and subtract
  assign div_req.start = (state_q == S_BMUL);
  assign div_req.num   = {cum_q, {heq_pkg::OUT_W{1'b0}}}
                       - {{heq_pkg::OUT_W{1'b0}}, cum_q};
  assign div_req.den   = total_q;

  // memory port controls
  always_comb begin
    bin_re    = 1'b0;
    bin_raddr = pix_i.pixel;
    bin_we    = (state_q == S_CNTWR);
    tbl_re    = 1'b0;
    tbl_raddr = pix_i.pixel;
    tbl_we    = (state_q == S_BDIV) && div_rsp.done;
    case (state_q)
      S_IDLE: begin
        bin_re = acc && (pix_i.func == heq_pkg::FUNC_COUNT);
        tbl_re = acc && (pix_i.func == heq_pkg::FUNC_MAP) && table_valid_q;
      end
      S_BRD: begin
        bin_re    = 1'b1;
        bin_raddr = bin_q;
      end
      S_MAPRD: begin
        tbl_re    = 1'b1;
        tbl_raddr = idx_q;
      end
      default: begin
        bin_re = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    table_valid_d = table_valid_q;
    bin_d         = bin_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (pix_i.func)
            heq_pkg::FUNC_COUNT: begin
              state_d       = S_CNTWR;
              table_valid_d = 1'b0;
            end
            heq_pkg::FUNC_MAP: begin
              state_d = table_valid_q ? S_MAPOUT : S_BINIT;
            end
            heq_pkg::FUNC_CLEAR: begin
              table_valid_d = 1'b0;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CNTWR: begin
        state_d = S_IDLE;
      end
      S_MAPOUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      S_BINIT: begin
        bin_d   = '0;
        state_d = S_BRD;
      end
      S_BRD: begin
        state_d = S_BACC;
      end
      S_BACC: begin
        state_d = S_BMUL;
      end
      S_BMUL: begin
        state_d = S_BDIV;
      end
      S_BDIV: begin
        if (div_rsp.done) begin
          if (bin_q == BIN_LAST) begin
            table_valid_d = 1'b1;
            state_d       = S_MAPRD;
          end else begin
            bin_d   = bin_q + 1'b1;
            state_d = S_BRD;
          end
        end
      end
      S_MAPRD: begin
        state_d = S_MAPOUT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      table_valid_q <= 1'b0;
      bin_q         <= '0;
      out_vld_q     <= 1'b0;
      bin_vld_q     <= '0;
      width_q       <= heq_pkg::DIM_RST;
      height_q      <= heq_pkg::DIM_RST;
    end else begin
      state_q       <= state_d;
      table_valid_q <= table_valid_d;
      bin_q         <= bin_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      // clear empties the whole histogram at once through the valid flops
      if (acc && (pix_i.func == heq_pkg::FUNC_CLEAR)) begin
        bin_vld_q <= '0;
      end else if (bin_we) begin
        bin_vld_q[idx_q] <= 1'b1;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          heq_pkg::REG_WIDTH:  width_q  <= cfg_i.data;
          heq_pkg::REG_HEIGHT: height_q <= cfg_i.data;
          default:             width_q  <= width_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      idx_q <= pix_i.pixel;
    end
    if (bin_re) begin
      bvld_rd_q <= bin_vld_q[bin_raddr];
    end
    if (state_q == S_BINIT) begin
      total_q <= tot_prod[heq_pkg::TOT_W-1:0];
      cum_q   <= '0;
    end else if (state_q == S_BACC) begin
      cum_q <= cum_q + {{(heq_pkg::CUM_W - heq_pkg::BIN_W){1'b0}}, bin_eff};
    end
    if (out_load) begin
      out_pix_q <= tbl_rdata;
    end
  end

  heq_ram #(
    .DEPTH (heq_pkg::GRAY_LEVELS),
    .WIDTH (heq_pkg::BIN_W)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (idx_q),
    .wdata_i (bin_inc),
    .re_i    (bin_re),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  heq_ram #(
    .DEPTH (heq_pkg::GRAY_LEVELS),
    .WIDTH (heq_pkg::OUT_W)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (bin_q),
    .wdata_i (div_rsp.quot),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  heq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  `HEQ_ASSERT(a_div_done_in_build, div_rsp.done |-> (state_q == S_BDIV))
  `HEQ_ASSERT(a_build_sets_table, (state_q == S_BDIV && div_rsp.done && bin_q == BIN_LAST) |=> table_valid_q)
  `HEQ_ASSERT(a_map_out_has_table, (state_q == S_MAPOUT) |-> table_valid_q)
  `HEQ_ASSERT(a_cnt_wr_after_idle, (state_q == S_CNTWR) |-> ($past(state_q) == S_IDLE))
  `HEQ_ASSERT_RST(a_reset_idle, !rst_ni |=> (state_q == S_IDLE && !out_vld_q))

endmodule

// ----- hw/rtl/heq_ram.sv -----
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps
module heq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/heq_div.sv -----
// iterative saturating divider, one quotient bit per cycle
`timescale 1ns / 1ps
module heq_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  heq_pkg::div_req_t req_i,
  output heq_pkg::div_rsp_t rsp_o
);

  localparam logic [heq_pkg::CNT_W-1:0] CNT_LAST = heq_pkg::CNT_W'(heq_pkg::OUT_W - 1);

  logic                        busy_q;
  logic                        done_q;
  logic [heq_pkg::CNT_W-1:0]   cnt_q;
  logic [heq_pkg::REM_W-1:0]   rem_q;
  logic [heq_pkg::REM_W-1:0]   dsh_q;
  logic [heq_pkg::OUT_W-1:0]   quot_q;
  logic [heq_pkg::NUM_W-1:0]   sat_lim;
  logic                        sat;
  logic                        fit;

  // quotient reaches 256 or more when num >= den * 256
  assign sat_lim = {{(heq_pkg::NUM_W - heq_pkg::REM_W){1'b0}}, req_i.den,
                    {heq_pkg::OUT_W{1'b0}}};
  assign sat     = (req_i.num >= sat_lim);
  assign fit     = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= '0;
        if (sat) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.num[heq_pkg::REM_W-1:0];
      dsh_q  <= {1'b0, req_i.den, {(heq_pkg::OUT_W - 1){1'b0}}};
      quot_q <= sat ? heq_pkg::OUT_MAX : '0;
    end else if (busy_q) begin
      if (fit) begin
        rem_q <= rem_q - dsh_q;
      end
      quot_q <= {quot_q[heq_pkg::OUT_W-2:0], fit};
      dsh_q  <= dsh_q >> 1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule
